// ===== hw/rtl/mit_pkg.sv =====
// Shared constants and types for the 3x3 inverse transpose block.
package mit_pkg;

	localparam int PORT_W         = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ELEM_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int N_ELEM         = 9;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_FIN
	} bk_state_t;

endpackage

// ===== hw/rtl/mit_fifo.sv =====
// Two-entry queue between the cofactor front end and the divider back end.
module mit_fifo import mit_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_stall,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_stall,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_stall = (count_q == 2'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/mit_front.sv =====
// Front end: cofactors, determinant and magnitudes in a six-stage pipeline.
module mit_front import mit_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	localparam int E   = ELEM_WIDTH,
	localparam int CW  = 2 * E,
	localparam int DW  = 3 * E + 2,
	localparam int DMW = 3 * E + 1,
	localparam int QW  = N_ELEM * CW + N_ELEM + DMW + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [N_ELEM-1:0][PORT_W-1:0]  elem,
	output logic                           push_valid,
	input  logic                           push_stall,
	output logic [QW-1:0]                  push_data
);

	logic signed [E-1:0]    a [3][3];
	logic signed [CW-1:0]   p1_s1 [3][3];
	logic signed [CW-1:0]   p2_s1 [3][3];
	logic signed [E-1:0]    row0_s1 [3];
	logic signed [CW-1:0]   cof_s2 [3][3];
	logic signed [E-1:0]    row0_s2 [3];
	logic signed [CW:0]     plo_s3 [3];
	logic signed [CW-1:0]   phi_s3 [3];
	logic signed [CW-1:0]   cof_s3 [3][3];
	logic signed [DW-1:0]   term_s4 [3];
	logic signed [CW-1:0]   cof_s4 [3][3];
	logic signed [DW-1:0]   det_s5;
	logic signed [CW-1:0]   cof_s5 [3][3];
	logic [QW-1:0]          data_s6;
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic                   adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !v_s6 || !push_stall;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall   = !adv1;
	assign push_valid = v_s6;
	assign push_data  = data_s6;

	always_comb begin
		for (int k = 0; k < N_ELEM; k++) begin
			a[k / 3][k % 3] = $signed(elem[k][E-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// stage 1: minor products
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p1_s1[i][j] <= a[(i == 0) ? 1 : 0][(j == 0) ? 1 : 0]
						* a[(i == 2) ? 1 : 2][(j == 2) ? 1 : 2];
					p2_s1[i][j] <= a[(i == 0) ? 1 : 0][(j == 2) ? 1 : 2]
						* a[(i == 2) ? 1 : 2][(j == 0) ? 1 : 0];
				end
				row0_s1[i] <= a[0][i];
			end
		end
	end

	// stage 2: signed cofactors
	always_ff @(posedge clk) begin
		logic signed [CW:0] m;
		if (adv2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					m = (CW+1)'(p1_s1[i][j]) - (CW+1)'(p2_s1[i][j]);
					cof_s2[i][j] <= ((i + j) % 2 == 1) ? CW'(-m) : CW'(m);
				end
				row0_s2[i] <= row0_s1[i];
			end
		end
	end

	// stage 3: determinant partial products, cofactor split in two halves
	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= row0_s2[j] * $signed({1'b0, cof_s2[0][j][E-1:0]});
				phi_s3[j] <= row0_s2[j] * $signed(cof_s2[0][j][CW-1:E]);
			end
			cof_s3 <= cof_s2;
		end
	end

	// stage 4: recombine halves
	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int j = 0; j < 3; j++) begin
				term_s4[j] <= (DW'(phi_s3[j]) <<< E) + DW'(plo_s3[j]);
			end
			cof_s4 <= cof_s3;
		end
	end

	// stage 5: determinant
	always_ff @(posedge clk) begin
		if (adv5) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s5 <= cof_s4;
		end
	end

	// stage 6: magnitudes, quotient signs, singular flag
	always_ff @(posedge clk) begin
		logic                 dneg;
		logic signed [DW-1:0] dabs;
		logic signed [CW-1:0] c;
		if (adv6) begin
			dneg = det_s5[DW-1];
			dabs = dneg ? -det_s5 : det_s5;
			for (int k = 0; k < N_ELEM; k++) begin
				c = cof_s5[k / 3][k % 3];
				data_s6[k*CW +: CW] <= c[CW-1] ? CW'(-c) : CW'(c);
				data_s6[N_ELEM*CW + k] <= c[CW-1] ^ dneg;
			end
			data_s6[N_ELEM*CW + N_ELEM +: DMW] <= dabs[DMW-1:0];
			data_s6[QW-1] <= (det_s5 == '0);
		end
	end

endmodule

// ===== hw/rtl/mit_back.sv =====
// Back end: nine restoring dividers sharing one divisor, saturation, output register.
module mit_back import mit_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	localparam int E   = ELEM_WIDTH,
	localparam int CW  = 2 * E,
	localparam int DMW = 3 * E + 1,
	localparam int QW  = N_ELEM * CW + N_ELEM + DMW + 1,
	localparam int NW  = CW + 2 * FRAC_BITS,
	localparam int QB  = E + 1,
	localparam int RW  = ((NW > DMW + QB) ? NW : DMW + QB) + 1,
	localparam int SCW = $clog2(QB + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_stall,
	input  logic [QW-1:0]                 pop_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [N_ELEM-1:0][PORT_W-1:0] res,
	output logic                          singular,
	output logic                          overflow
);

	bk_state_t            state_q, state_d;
	logic [RW-1:0]        rem_q [N_ELEM];
	logic [QB:0]          quo_q [N_ELEM];
	logic [N_ELEM-1:0]    neg_q;
	logic [RW-1:0]        dsh_q;
	logic [SCW-1:0]       step_q;
	logic                 sing_q;
	logic                 out_valid_q;
	logic [N_ELEM-1:0][PORT_W-1:0] res_q;
	logic                 sing_out_q;
	logic                 ovf_q;
	logic                 out_free;
	logic                 do_load;
	logic                 do_step;
	logic                 do_out;
	logic [N_ELEM-1:0][PORT_W-1:0] res_d;
	logic                 ovf_d;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign singular  = sing_out_q;
	assign overflow  = ovf_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) state_d = pop_data[QW-1] ? BK_FIN : BK_RUN;
			end
			BK_RUN: begin
				if (step_q == '0) state_d = BK_FIN;
			end
			BK_FIN: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop_stall = 1'b1;
		do_load   = 1'b0;
		do_step   = 1'b0;
		do_out    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop_stall = 1'b0;
				do_load   = pop_valid;
			end
			BK_RUN:  do_step = 1'b1;
			BK_FIN:  do_out  = out_free;
			default: pop_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// top quotient bit flags a quotient of 2^(E+1) or more
	always_ff @(posedge clk) begin
		logic [RW:0] diff;
		if (do_load) begin
			for (int l = 0; l < N_ELEM; l++) begin
				rem_q[l] <= RW'(pop_data[l*CW +: CW]) << (2 * FRAC_BITS);
				quo_q[l] <= '0;
			end
			neg_q  <= pop_data[N_ELEM*CW +: N_ELEM];
			dsh_q  <= RW'(pop_data[N_ELEM*CW + N_ELEM +: DMW]) << QB;
			sing_q <= pop_data[QW-1];
			step_q <= SCW'(QB);
		end else if (do_step) begin
			for (int l = 0; l < N_ELEM; l++) begin
				diff = {1'b0, rem_q[l]} - {1'b0, dsh_q};
				if (!diff[RW]) begin
					rem_q[l] <= diff[RW-1:0];
				end
				quo_q[l] <= {quo_q[l][QB-1:0], ~diff[RW]};
			end
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - SCW'(1);
		end
	end

	always_comb begin
		logic [E:0]   lo;
		logic         sat;
		logic [E-1:0] v;
		ovf_d = 1'b0;
		for (int l = 0; l < N_ELEM; l++) begin
			lo = quo_q[l][E:0];
			if (neg_q[l]) begin
				sat = quo_q[l][QB] || (lo > ((E+1)'(1) << (E - 1)));
				v   = sat ? {1'b1, {(E-1){1'b0}}} : E'(-lo);
			end else begin
				sat = quo_q[l][QB] || (lo > (((E+1)'(1) << (E - 1)) - (E+1)'(1)));
				v   = sat ? {1'b0, {(E-1){1'b1}}} : lo[E-1:0];
			end
			if (sing_q) begin
				sat = 1'b0;
				v   = '0;
			end
			ovf_d    = ovf_d | sat;
			res_d[l] = PORT_W'($signed(v));
		end
	end

	always_ff @(posedge clk) begin
		if (do_out) begin
			res_q      <= res_d;
			sing_out_q <= sing_q;
			ovf_q      <= ovf_d;
		end
	end

endmodule

// ===== hw/rtl/matrix_inverse_transpose_3x3.sv =====
// Top level of the 3x3 fixed-point inverse transpose block.
//
// One input transaction carries the nine elements of a 3x3 matrix in signed
// fixed point (FRAC_BITS fraction bits, low ELEM_WIDTH bits of each port used).
// One output transaction returns trunc(C * 2^(2*FRAC_BITS) / D) for every
// cofactor C and the determinant D, plus singular and overflow flags.
// Singular matrix: all elements zero, singular set. Out-of-range elements
// saturate and set overflow.
// Both channels use valid/stall; a transaction moves when valid is high and stall is low.
// Front end: six pipeline stages (minor products, cofactors, split determinant
// products, recombine, sum, magnitudes); it takes one matrix per cycle unless stalled.
// A two-entry queue decouples it from the back end.
// Back end: nine restoring dividers sharing one shifted divisor, one quotient
// bit per cycle; it handles one matrix at a time in three phases:
// load, ELEM_WIDTH + 2 divide steps, result. A singular matrix skips the divide
// steps. That divider loop sets the throughput. A finished result waits in the
// output register while the next matrix is divided; a stalled receiver holds
// the result steady and backs up the queue and then the front pipeline. Reset
// empties all pipelines and the queue.
module matrix_inverse_transpose_3x3 import mit_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PORT_W-1:0] in_r0_c0,
	input  logic [PORT_W-1:0] in_r0_c1,
	input  logic [PORT_W-1:0] in_r0_c2,
	input  logic [PORT_W-1:0] in_r1_c0,
	input  logic [PORT_W-1:0] in_r1_c1,
	input  logic [PORT_W-1:0] in_r1_c2,
	input  logic [PORT_W-1:0] in_r2_c0,
	input  logic [PORT_W-1:0] in_r2_c1,
	input  logic [PORT_W-1:0] in_r2_c2,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PORT_W-1:0] out_r0_c0,
	output logic [PORT_W-1:0] out_r0_c1,
	output logic [PORT_W-1:0] out_r0_c2,
	output logic [PORT_W-1:0] out_r1_c0,
	output logic [PORT_W-1:0] out_r1_c1,
	output logic [PORT_W-1:0] out_r1_c2,
	output logic [PORT_W-1:0] out_r2_c0,
	output logic [PORT_W-1:0] out_r2_c1,
	output logic [PORT_W-1:0] out_r2_c2,
	output logic              singular,
	output logic              overflow
);

	// queue entry: nine cofactor magnitudes, nine quotient signs,
	// determinant magnitude, singular flag
	localparam int QW = N_ELEM * 2 * ELEM_WIDTH + N_ELEM + 3 * ELEM_WIDTH + 2;

	logic [N_ELEM-1:0][PORT_W-1:0] elem;
	logic [N_ELEM-1:0][PORT_W-1:0] res;
	logic                          push_valid;
	logic                          push_stall;
	logic [QW-1:0]                 push_data;
	logic                          pop_valid;
	logic                          pop_stall;
	logic [QW-1:0]                 pop_data;

	assign elem = {in_r2_c2, in_r2_c1, in_r2_c0,
	               in_r1_c2, in_r1_c1, in_r1_c0,
	               in_r0_c2, in_r0_c1, in_r0_c0};

	assign out_r0_c0 = res[0];
	assign out_r0_c1 = res[1];
	assign out_r0_c2 = res[2];
	assign out_r1_c0 = res[3];
	assign out_r1_c1 = res[4];
	assign out_r1_c2 = res[5];
	assign out_r2_c0 = res[6];
	assign out_r2_c1 = res[7];
	assign out_r2_c2 = res[8];

	mit_front #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.elem       (elem),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data)
	);

	mit_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_data   (pop_data)
	);

	mit_back #(
		.FRAC_BITS  (FRAC_BITS),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_stall (pop_stall),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.singular  (singular),
		.overflow  (overflow)
	);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the 3x3 fixed-point inverse transpose block.
module tb;
	import mit_pkg::*;

	typedef logic signed [PORT_W-1:0] elem_t;

	// One expected result: nine elements plus the two flags.
	typedef struct {
		elem_t el [N_ELEM];
		logic  sing;
		logic  ovf;
	} inv_result_t;

	// Predicts the inverse transpose at the default widths and keeps the
	// expected results in arrival order.
	class inv_scoreboard;
		inv_result_t pending[$];
		int          errors;

		function inv_result_t predict(elem_t m [N_ELEM]);
			inv_result_t         r;
			logic signed [127:0] a [3][3];
			logic signed [127:0] cof [3][3];
			logic signed [127:0] det;
			logic signed [127:0] num;
			logic signed [127:0] q;
			logic signed [127:0] lim_hi;
			logic signed [127:0] lim_lo;
			int                  r0, r1, c0, c1;
			lim_hi = 128'sd2147483647;
			lim_lo = -128'sd2147483648;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					a[i][j] = m[i*3+j];
			for (int i = 0; i < 3; i++) begin
				r0 = (i == 0) ? 1 : 0;
				r1 = (i == 2) ? 1 : 2;
				for (int j = 0; j < 3; j++) begin
					c0 = (j == 0) ? 1 : 0;
					c1 = (j == 2) ? 1 : 2;
					cof[i][j] = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
					if ((i + j) % 2) cof[i][j] = -cof[i][j];
				end
			end
			det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
			r.sing = (det == 0);
			r.ovf = 1'b0;
			for (int k = 0; k < N_ELEM; k++) begin
				if (r.sing) begin
					r.el[k] = '0;
				end else begin
					// Signed division in SV truncates toward zero.
					num = cof[k/3][k%3] <<< (2 * FRAC_BITS_DEF);
					q = num / det;
					if (q > lim_hi) begin
						q = lim_hi;
						r.ovf = 1'b1;
					end else if (q < lim_lo) begin
						q = lim_lo;
						r.ovf = 1'b1;
					end
					r.el[k] = q[PORT_W-1:0];
				end
			end
			return r;
		endfunction

		function void note_input(elem_t m [N_ELEM]);
			pending.push_back(predict(m));
		endfunction

		function void check_result(inv_result_t got);
			inv_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected transaction at output", $time);
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int k = 0; k < N_ELEM; k++)
				if (got.el[k] !== want.el[k]) begin
					$display("%0t: element %0d expected %h actual %h",
						$time, k, want.el[k], got.el[k]);
					errors++;
				end
			if (got.sing !== want.sing) begin
				$display("%0t: singular expected %b actual %b", $time, want.sing, got.sing);
				errors++;
			end
			if (got.ovf !== want.ovf) begin
				$display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	elem_t in_el [N_ELEM];
	logic  out_valid;
	logic  out_stall = 1'b1;
	elem_t out_el [N_ELEM];
	logic  singular, overflow;

	inv_scoreboard sb = new();
	int  idle_cycles;
	bit  stim_done;
	// Set by the stimulus to force a long receiver hold-off.
	bit  hold_req;

	initial for (int k = 0; k < N_ELEM; k++) in_el[k] = '0;

	always #5 clk = ~clk;

	matrix_inverse_transpose_3x3 DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_r0_c0(in_el[0]), .in_r0_c1(in_el[1]), .in_r0_c2(in_el[2]),
		.in_r1_c0(in_el[3]), .in_r1_c1(in_el[4]), .in_r1_c2(in_el[5]),
		.in_r2_c0(in_el[6]), .in_r2_c1(in_el[7]), .in_r2_c2(in_el[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_r0_c0(out_el[0]), .out_r0_c1(out_el[1]), .out_r0_c2(out_el[2]),
		.out_r1_c0(out_el[3]), .out_r1_c1(out_el[4]), .out_r1_c2(out_el[5]),
		.out_r2_c0(out_el[6]), .out_r2_c1(out_el[7]), .out_r2_c2(out_el[8]),
		.singular(singular), .overflow(overflow)
	);

	// Output side: a transaction completes when valid is high and stall low
	// at the edge; sample and check it, then pick the next stall value.
	always @(posedge clk) begin
		inv_result_t got;
		int          mode;
		if (arst_n && out_valid && !out_stall) begin
			for (int k = 0; k < N_ELEM; k++) got.el[k] = out_el[k];
			got.sing = singular;
			got.ovf = overflow;
			sb.check_result(got);
		end
		// Stall pattern rotates through three modes over time: free running,
		// light stalls, heavy stalls.
		mode = ($time / 3000) % 3;
		if (!arst_n || hold_req) out_stall <= 1'b1;
		else if (mode == 0) out_stall <= 1'b0;
		else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= ($urandom_range(0, 3) != 0);
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one matrix and hold it until accepted.
	task automatic send_matrix(elem_t m [N_ELEM]);
		in_valid <= 1'b1;
		for (int k = 0; k < N_ELEM; k++) in_el[k] <= m[k];
		do @(posedge clk); while (in_stall);
		sb.note_input(m);
	endtask

	task automatic pause_sender(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Random element: mostly small values near one so that the inverse stays
	// in range, sometimes full-width values to hit overflow and sign bits.
	function automatic elem_t rand_elem();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom;
			2:       return $signed($urandom_range(0, 65535)) - 32768;
			3:       return elem_t'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
			default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	task automatic send_random();
		elem_t m [N_ELEM];
		int    shape;
		for (int k = 0; k < N_ELEM; k++) m[k] = rand_elem();
		shape = $urandom_range(0, 9);
		// Singular shapes: duplicated row, zero column, scaled row.
		if (shape == 0) for (int j = 0; j < 3; j++) m[6+j] = m[j];
		else if (shape == 1) for (int i = 0; i < 3; i++) m[i*3+1] = '0;
		else if (shape == 2) for (int j = 0; j < 3; j++) m[3+j] = m[j] * 2;
		send_matrix(m);
	endtask

	initial begin
		elem_t m [N_ELEM];
		stim_done = 0;
		hold_req = 0;
		idle_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity, diagonal, zero, extremes, singular cases.
		m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		send_matrix(m);
		m = '{32'h20000, 0, 0, 0, -32'sh8000, 0, 0, 0, 32'h30000};
		send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
		for (int k = 0; k < N_ELEM; k++) m[k] = elem_t'(32'h7fffffff);
		send_matrix(m);
		m = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
		send_matrix(m);
		m = '{32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff};
		send_matrix(m);
		// Tiny determinant: every nonzero element saturates.
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(m);
		m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(m);
		m = '{0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 32'h10000};
		send_matrix(m);
		m = '{32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000,
			32'h70000, 32'h80000, 32'h90000};
		send_matrix(m);
		m = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff};
		send_matrix(m);
		m = '{-1, -1, 32'h1234, 5, -32'sh10000, 7, 32'hffff, 3, -9};
		send_matrix(m);

		// Pressure: receiver holds off while the sender keeps offering.
		hold_req = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_req = 0;
			end
			repeat (20) send_random();
		join

		// Random bursts with random gaps.
		for (int n = 0; n < 1900; ) begin
			int burst;
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst; b++) send_random();
			n += burst;
			if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 60));
		end
		in_valid <= 1'b0;
		stim_done = 1;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== matrix_inverse_transpose_3x3.f =====
hw/rtl/mit_pkg.sv
hw/rtl/mit_fifo.sv
hw/rtl/mit_front.sv
hw/rtl/mit_back.sv
hw/rtl/matrix_inverse_transpose_3x3.sv
sim/tb.sv
